@@ sv/ked_pkg.sv @@
package ked_pkg;

    localparam int unsigned KeyW  = 9;
    localparam int unsigned PosW  = 10;
    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgIdxW = 2;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegScreenRows = 2'd0;
    localparam logic [CfgIdxW-1:0] RegScreenCols = 2'd1;

    localparam logic [PosW-1:0] ScreenRowsReset = 10'd24;
    localparam logic [PosW-1:0] ScreenColsReset = 10'd80;

    // input commands
    localparam logic CmdByte    = 1'b0;
    localparam logic CmdTimeout = 1'b1;

    // bytes of interest
    localparam logic [ByteW-1:0] ByteEsc     = 8'h1b;
    localparam logic [ByteW-1:0] ByteCsi     = 8'h5b; // [
    localparam logic [ByteW-1:0] ByteSs3     = 8'h4f; // O
    localparam logic [ByteW-1:0] ByteTilde   = 8'h7e;
    localparam logic [ByteW-1:0] ByteDigit0  = 8'h30;
    localparam logic [ByteW-1:0] ByteDigit9  = 8'h39;
    localparam logic [ByteW-1:0] ByteCtrlQ   = 8'h11;

    // key codes
    localparam logic [KeyW-1:0] KeyEsc   = 9'd27;
    localparam logic [KeyW-1:0] KeyQuit  = 9'h011;
    localparam logic [KeyW-1:0] KeyH     = 9'h068;
    localparam logic [KeyW-1:0] KeyJ     = 9'h06a;
    localparam logic [KeyW-1:0] KeyK     = 9'h06b;
    localparam logic [KeyW-1:0] KeyL     = 9'h06c;
    localparam logic [KeyW-1:0] KeyLeft  = 9'd256;
    localparam logic [KeyW-1:0] KeyRight = 9'd257;
    localparam logic [KeyW-1:0] KeyUp    = 9'd258;
    localparam logic [KeyW-1:0] KeyDown  = 9'd259;
    localparam logic [KeyW-1:0] KeyPgUp  = 9'd260;
    localparam logic [KeyW-1:0] KeyPgDn  = 9'd261;
    localparam logic [KeyW-1:0] KeyHome  = 9'd262;
    localparam logic [KeyW-1:0] KeyEnd   = 9'd263;
    localparam logic [KeyW-1:0] KeyDel   = 9'd264;

    typedef struct packed {
        logic             cmd;
        logic [ByteW-1:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [KeyW-1:0] key_code;
        logic [PosW-1:0] cursor_col;
        logic [PosW-1:0] cursor_row;
        logic            quit;
    } out_item_t;

    // ESC [ digit ~
    function automatic logic [KeyW-1:0] tilde_key(input logic [ByteW-1:0] d);
        logic [KeyW-1:0] k;
        case (d)
            8'h31, 8'h37: k = KeyHome;
            8'h34, 8'h38: k = KeyEnd;
            8'h32, 8'h35: k = KeyPgUp;
            8'h36:        k = KeyPgDn;
            8'h33:        k = KeyDel;
            default:      k = KeyEsc;
        endcase
        return k;
    endfunction

    // ESC [ letter
    function automatic logic [KeyW-1:0] csi_letter(input logic [ByteW-1:0] b);
        logic [KeyW-1:0] k;
        case (b)
            8'h41:   k = KeyUp;
            8'h42:   k = KeyDown;
            8'h43:   k = KeyRight;
            8'h44:   k = KeyLeft;
            8'h48:   k = KeyHome;
            8'h46:   k = KeyEnd;
            default: k = KeyEsc;
        endcase
        return k;
    endfunction

    // ESC O letter
    function automatic logic [KeyW-1:0] ss3_letter(input logic [ByteW-1:0] b);
        logic [KeyW-1:0] k;
        case (b)
            8'h48:   k = KeyHome;
            8'h46:   k = KeyEnd;
            default: k = KeyEsc;
        endcase
        return k;
    endfunction

endpackage

@@ sv/key_escape_decoder_cursor.sv @@
// Channel  Direction  Handshake        Payload
// in       input      valid / stall    in_data   (cmd, byte_value)
// out      output     valid / stall    out_data  (key_code, cursor_col, cursor_row, quit)
// cfg      input      valid / ready    cfg_index, cfg_data (screen_rows, screen_cols)
//
// One beat is taken per cycle unless in stalls; its key, if any, is registered for out.
// Parser and cursor state advance when the beat is taken; an output register
// plus one skid entry part the two sides, so in stalls only while the skid is full.
// Reset clears parser, cursor, and the valid flags of both output slots; screen size returns to 24 x 80.
// cfg_ready is always high.
module key_escape_decoder_cursor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ked_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ked_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ked_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ked_pkg::PosW-1:0]      cfg_data
);

    localparam logic [2:0] PhIdle  = 3'd0;
    localparam logic [2:0] PhEsc   = 3'd1;
    localparam logic [2:0] PhCsi   = 3'd2;
    localparam logic [2:0] PhSs3   = 3'd3;
    localparam logic [2:0] PhSkip  = 3'd4;
    localparam logic [2:0] PhDigit = 3'd5;

    logic [ked_pkg::PosW-1:0]  screen_rows_reg;
    logic [ked_pkg::PosW-1:0]  screen_cols_reg;
    logic [2:0]                phase_reg;
    logic [2:0]                phase_next;
    logic [ked_pkg::ByteW-1:0] digit_reg;
    logic [ked_pkg::ByteW-1:0] digit_next;
    logic [ked_pkg::PosW-1:0]  col_reg;
    logic [ked_pkg::PosW-1:0]  col_next;
    logic [ked_pkg::PosW-1:0]  row_reg;
    logic [ked_pkg::PosW-1:0]  row_next;

    logic                      out_valid_reg;
    ked_pkg::out_item_t        out_data_reg;
    logic                      skid_valid_reg;
    ked_pkg::out_item_t        skid_data_reg;

    logic                      in_fire;
    logic                      out_fire;
    logic                      emit;
    logic [ked_pkg::KeyW-1:0]  key;
    logic [ked_pkg::PosW-1:0]  max_row;
    logic [ked_pkg::PosW-1:0]  max_col;
    logic [ked_pkg::PosW-1:0]  row_clamp;
    logic [ked_pkg::PosW-1:0]  col_clamp;
    logic                      timeout;
    logic [ked_pkg::ByteW-1:0] b;
    ked_pkg::out_item_t        res;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign timeout = (in_data.cmd == ked_pkg::CmdTimeout);
    assign b       = in_data.byte_value;

    // zero size counts as one
    assign max_row   = (screen_rows_reg == '0) ? '0 : screen_rows_reg - 1'b1;
    assign max_col   = (screen_cols_reg == '0) ? '0 : screen_cols_reg - 1'b1;
    assign row_clamp = (row_reg > max_row) ? max_row : row_reg;
    assign col_clamp = (col_reg > max_col) ? max_col : col_reg;

    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        emit       = 1'b0;
        key        = ked_pkg::KeyEsc;
        if (phase_reg == PhIdle)
        begin
            if (!timeout)
            begin
                if (b == ked_pkg::ByteEsc)
                    phase_next = PhEsc;
                else
                begin
                    emit = 1'b1;
                    key  = {1'b0, b};
                end
            end
        end
        else if (timeout)
        begin
            phase_next = PhIdle;
            emit       = 1'b1;
        end
        else
        begin
            phase_next = PhIdle;
            emit       = 1'b1;
            case (phase_reg)
                PhEsc:
                begin
                    emit = 1'b0;
                    if (b == ked_pkg::ByteCsi)
                        phase_next = PhCsi;
                    else if (b == ked_pkg::ByteSs3)
                        phase_next = PhSs3;
                    else
                        phase_next = PhSkip;
                end
                PhCsi:
                begin
                    if (b >= ked_pkg::ByteDigit0 && b <= ked_pkg::ByteDigit9)
                    begin
                        emit       = 1'b0;
                        digit_next = b;
                        phase_next = PhDigit;
                    end
                    else
                        key = ked_pkg::csi_letter(b);
                end
                PhSs3:   key = ked_pkg::ss3_letter(b);
                PhDigit: key = (b == ked_pkg::ByteTilde) ? ked_pkg::tilde_key(digit_reg)
                                                         : ked_pkg::KeyEsc;
                default: key = ked_pkg::KeyEsc;
            endcase
        end
    end

    always_comb
    begin
        row_next = row_clamp;
        col_next = col_clamp;
        case (key)
            ked_pkg::KeyK, ked_pkg::KeyUp:
                if (row_clamp != '0) row_next = row_clamp - 1'b1;
            ked_pkg::KeyJ, ked_pkg::KeyDown:
                if (row_clamp < max_row) row_next = row_clamp + 1'b1;
            ked_pkg::KeyL, ked_pkg::KeyRight:
                if (col_clamp < max_col) col_next = col_clamp + 1'b1;
            ked_pkg::KeyH, ked_pkg::KeyLeft:
                if (col_clamp != '0) col_next = col_clamp - 1'b1;
            ked_pkg::KeyPgUp: row_next = '0;
            ked_pkg::KeyPgDn: row_next = max_row;
            ked_pkg::KeyHome: col_next = '0;
            ked_pkg::KeyEnd:  col_next = max_col;
            default: ;
        endcase
        res.key_code   = key;
        res.cursor_col = col_next;
        res.cursor_row = row_next;
        res.quit       = (key == ked_pkg::KeyQuit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_rows_reg <= ked_pkg::ScreenRowsReset;
            screen_cols_reg <= ked_pkg::ScreenColsReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ked_pkg::RegScreenRows)
                screen_rows_reg <= cfg_data;
            else if (cfg_index == ked_pkg::RegScreenCols)
                screen_cols_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PhIdle;
            digit_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
            // cursor only moves when a key is reported
            if (emit)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= in_fire && emit;
        end
        else if (in_fire && emit)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire && emit)
                out_data_reg <= res;
        end
        else if (in_fire && emit)
            skid_data_reg <= res;
    end

endmodule

@@ tb/key_decode_monitor.sv @@
`timescale 1ns / 100ps

module key_decode_monitor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  ked_pkg::in_item_t           in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  ked_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [ked_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [ked_pkg::PosW-1:0]    cfg_data,
    output int                          errors,
    output int                          waiting,
    output int                          keys_checked
);
    import ked_pkg::*;

    typedef enum logic [2:0] {
        PhIdle,
        PhEsc,
        PhCsi,
        PhSs3,
        PhSkip,
        PhDigit
    } parse_phase_t;

    localparam logic [ByteW-1:0] ChA = "A";
    localparam logic [ByteW-1:0] ChB = "B";
    localparam logic [ByteW-1:0] ChC = "C";
    localparam logic [ByteW-1:0] ChD = "D";
    localparam logic [ByteW-1:0] ChF = "F";
    localparam logic [ByteW-1:0] ChH = "H";
    localparam logic [ByteW-1:0] Ch1 = "1";
    localparam logic [ByteW-1:0] Ch2 = "2";
    localparam logic [ByteW-1:0] Ch3 = "3";
    localparam logic [ByteW-1:0] Ch4 = "4";
    localparam logic [ByteW-1:0] Ch5 = "5";
    localparam logic [ByteW-1:0] Ch6 = "6";
    localparam logic [ByteW-1:0] Ch7 = "7";
    localparam logic [ByteW-1:0] Ch8 = "8";

    parse_phase_t     phase;
    logic [ByteW-1:0] held_digit;
    logic [PosW-1:0]  col_pos;
    logic [PosW-1:0]  row_pos;
    logic [PosW-1:0]  rows_reg;
    logic [PosW-1:0]  cols_reg;
    out_item_t        expected_keys[$];
    int               fail_count = 0;
    int               checked_count = 0;
    int               pending_count = 0;

    assign errors       = fail_count;
    assign waiting      = pending_count;
    assign keys_checked = checked_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // apply the key to the clamped cursor and queue the key it reports
    task automatic move_cursor(input logic [KeyW-1:0] key);
        logic [PosW-1:0] last_row;
        logic [PosW-1:0] last_col;
        out_item_t       want;
        last_row = (rows_reg == '0) ? '0 : rows_reg - 1'b1;
        last_col = (cols_reg == '0) ? '0 : cols_reg - 1'b1;
        if (row_pos > last_row) row_pos = last_row;
        if (col_pos > last_col) col_pos = last_col;
        case (key)
            KeyK, KeyUp:    if (row_pos != '0) row_pos = row_pos - 1'b1;
            KeyJ, KeyDown:  if (row_pos < last_row) row_pos = row_pos + 1'b1;
            KeyL, KeyRight: if (col_pos < last_col) col_pos = col_pos + 1'b1;
            KeyH, KeyLeft:  if (col_pos != '0) col_pos = col_pos - 1'b1;
            KeyPgUp:        row_pos = '0;
            KeyPgDn:        row_pos = last_row;
            KeyHome:        col_pos = '0;
            KeyEnd:         col_pos = last_col;
            default:        ;
        endcase
        want.key_code   = key;
        want.cursor_col = col_pos;
        want.cursor_row = row_pos;
        want.quit       = (key == KeyQuit);
        expected_keys.push_back(want);
    endtask

    task automatic decode_beat(input in_item_t beat);
        logic [KeyW-1:0]  key;
        logic [ByteW-1:0] b;
        bit               done;
        b    = beat.byte_value;
        key  = KeyEsc;
        done = 1'b0;
        if (phase == PhIdle)
        begin
            if (beat.cmd == CmdTimeout)
            begin
                // nothing pending: drop the timeout
            end
            else if (b == ByteEsc)
            begin
                phase = PhEsc;
            end
            else
            begin
                key  = {1'b0, b};
                done = 1'b1;
            end
        end
        else if (beat.cmd == CmdTimeout)
        begin
            phase = PhIdle;
            done  = 1'b1;
        end
        else
        begin
            case (phase)
                PhEsc:
                begin
                    if (b == ByteCsi)      phase = PhCsi;
                    else if (b == ByteSs3) phase = PhSs3;
                    else                   phase = PhSkip;
                end
                PhCsi:
                begin
                    if (b >= ByteDigit0 && b <= ByteDigit9)
                    begin
                        held_digit = b;
                        phase      = PhDigit;
                    end
                    else
                    begin
                        case (b)
                            ChA:     key = KeyUp;
                            ChB:     key = KeyDown;
                            ChC:     key = KeyRight;
                            ChD:     key = KeyLeft;
                            ChH:     key = KeyHome;
                            ChF:     key = KeyEnd;
                            default: key = KeyEsc;
                        endcase
                        done = 1'b1;
                    end
                end
                PhSs3:
                begin
                    if (b == ChH)      key = KeyHome;
                    else if (b == ChF) key = KeyEnd;
                    done = 1'b1;
                end
                PhDigit:
                begin
                    if (b == ByteTilde)
                    begin
                        case (held_digit)
                            Ch1, Ch7: key = KeyHome;
                            Ch4, Ch8: key = KeyEnd;
                            Ch2, Ch5: key = KeyPgUp;
                            Ch6:      key = KeyPgDn;
                            Ch3:      key = KeyDel;
                            default:  key = KeyEsc;
                        endcase
                    end
                    done = 1'b1;
                end
                default: done = 1'b1;
            endcase
            if (done) phase = PhIdle;
        end
        if (done) move_cursor(key);
    endtask

    task automatic check_key(input out_item_t got);
        out_item_t want;
        if (expected_keys.size() == 0)
        begin
            report_mismatch($sformatf("key %0d with none expected", got.key_code));
            return;
        end
        want = expected_keys.pop_front();
        checked_count++;
        if (got.key_code !== want.key_code)
            report_mismatch($sformatf("key_code %0d, expected %0d",
                                      got.key_code, want.key_code));
        if (got.cursor_col !== want.cursor_col)
            report_mismatch($sformatf("cursor_col %0d, expected %0d (key %0d)",
                                      got.cursor_col, want.cursor_col, want.key_code));
        if (got.cursor_row !== want.cursor_row)
            report_mismatch($sformatf("cursor_row %0d, expected %0d (key %0d)",
                                      got.cursor_row, want.cursor_row, want.key_code));
        if (got.quit !== want.quit)
            report_mismatch($sformatf("quit %0b, expected %0b (key %0d)",
                                      got.quit, want.quit, want.key_code));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase         = PhIdle;
            held_digit    = '0;
            col_pos       = '0;
            row_pos       = '0;
            rows_reg      = ScreenRowsReset;
            cols_reg      = ScreenColsReset;
            expected_keys.delete();
            pending_count = 0;
        end
        else
        begin
            // a key is registered before it leaves, never in its beat's cycle: compare before predicting
            if (out_valid && !out_stall) check_key(out_data);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    RegScreenRows: rows_reg = cfg_data;
                    RegScreenCols: cols_reg = cfg_data;
                    default:       ;
                endcase
            end
            if (in_valid && !in_stall) decode_beat(in_data);
            pending_count = expected_keys.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import ked_pkg::*;

    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
    localparam int                 NumPhases = 8;
    localparam int                 BeatsPerPhase = 95;
    localparam logic [ByteW-1:0]   ChX = "x";
    localparam logic [ByteW-1:0]   ChY = "y";

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [PosW-1:0]    cfg_data;

    int errors;
    int waiting;
    int keys_checked;
    int beats_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;
    int sizes_run  = 1;

    always #5 clk = ~clk;

    key_escape_decoder_cursor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_decode_monitor monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .waiting      (waiting),
        .keys_checked (keys_checked)
    );

    // final letters of ESC [ letter, in the order A B C D H F
    function automatic logic [ByteW-1:0] csi_final(input int idx);
        logic [ByteW-1:0] c;
        case (idx)
            0:       c = "A";
            1:       c = "B";
            2:       c = "C";
            3:       c = "D";
            4:       c = "H";
            default: c = "F";
        endcase
        return c;
    endfunction

    // receiver: switch between free-running, light, heavy and square-wave stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(40, 300);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_tick[3];
        endcase
    end

    task automatic send_beat(input logic kind, input logic [ByteW-1:0] b, input bit counted);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= {kind, b};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        if (counted) beats_sent++;
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b);
        send_beat(CmdByte, b, 1'b1);
    endtask

    task automatic send_timeout(input bit counted);
        send_beat(CmdTimeout, 8'($urandom_range(0, 255)), counted);
    endtask

    // drop valid and wait until every queued key has come out
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_screen(input logic [PosW-1:0] rows, input logic [PosW-1:0] cols,
                              input bit spare);
        write_reg(RegScreenRows, rows);
        write_reg(RegScreenCols, cols);
        if (spare) write_reg(RegUnused, 10'($urandom_range(0, 1023)));
        cfg_valid <= 1'b0;
        @(posedge clk);
        sizes_run++;
    endtask

    task automatic send_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            case ($urandom_range(0, 5))
                0:       send_byte(KeyH[ByteW-1:0]);
                1:       send_byte(KeyJ[ByteW-1:0]);
                2:       send_byte(KeyK[ByteW-1:0]);
                3:       send_byte(KeyL[ByteW-1:0]);
                4:       send_byte(ByteCtrlQ);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        else if (kind < 45)
        begin
            send_byte(ByteEsc);
            send_byte(ByteCsi);
            if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
            else                           send_byte(csi_final($urandom_range(0, 5)));
        end
        else if (kind < 55)
        begin
            send_byte(ByteEsc);
            send_byte(ByteSs3);
            case ($urandom_range(0, 2))
                0:       send_byte(csi_final(4));
                1:       send_byte(csi_final(5));
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        else if (kind < 75)
        begin
            send_byte(ByteEsc);
            send_byte(ByteCsi);
            send_byte(8'(ByteDigit0 + $urandom_range(0, 9)));
            if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
            else                           send_byte(ByteTilde);
        end
        else if (kind < 85)
        begin
            // broken sequence: time out part way in
            send_byte(ByteEsc);
            n = $urandom_range(0, 2);
            if (n > 0) send_byte(ByteCsi);
            if (n > 1) send_byte(8'(ByteDigit0 + $urandom_range(0, 9)));
            send_timeout(1'b1);
        end
        else if (kind < 90)
        begin
            send_byte(ByteEsc);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 95)
        begin
            send_timeout(1'b0);
        end
        else
        begin
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial
    begin
        int rows_plan[NumPhases];
        int cols_plan[NumPhases];
        int target;
        rows_plan = '{24, 1023, 3, 0, 1, 1023, 0, 0};
        cols_plan = '{80, 1023, 5, 0, 1, 2, 0, 0};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = RegScreenRows;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges of the cursor, raw byte extremes, quit, one of each sequence form
        send_byte(KeyK[ByteW-1:0]);
        send_byte(KeyH[ByteW-1:0]);
        send_byte(KeyJ[ByteW-1:0]);
        send_byte(KeyL[ByteW-1:0]);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(ByteCtrlQ);
        send_timeout(1'b0);
        send_byte(ByteEsc); send_byte(ByteCsi); send_byte(csi_final(0));
        send_byte(ByteEsc); send_byte(ByteSs3); send_byte(csi_final(5));
        send_byte(ByteEsc); send_byte(ByteCsi); send_byte(8'(ByteDigit0 + 3));
        send_byte(ByteTilde);
        send_byte(ByteEsc); send_byte(ByteCsi); send_byte(ByteDigit0); send_byte(ByteTilde);
        send_byte(ByteEsc); send_byte(ChX); send_byte(ChY);
        send_byte(ByteEsc); send_timeout(1'b1);
        send_byte(ByteEsc); send_byte(ByteCsi); send_byte(ByteDigit9); send_byte(ChX);

        for (int p = 0; p < NumPhases; p++)
        begin
            if (p > 0)
            begin
                drain();
                if (p >= 6)
                begin
                    rows_plan[p] = $urandom_range(1, 1023);
                    cols_plan[p] = $urandom_range(1, 1023);
                end
                set_screen(10'(rows_plan[p]), 10'(cols_plan[p]), p == 3);
            end
            target = beats_sent + BeatsPerPhase;
            while (beats_sent < target) send_random_sequence();
        end
        drain();

        $display("run covered %0d input beats and %0d decoded keys over %0d screen sizes",
                 beats_sent, keys_checked, sizes_run);
        $display("mismatches: %0d, keys still outstanding: %0d", errors, waiting);
        if (errors == 0 && waiting == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("watchdog expired with %0d keys outstanding", waiting);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
